>>> rtl/wtm_pkg.sv
// Package for the wavetable tone mixer: sizes, command and configuration types,
// and the ramp waveform table.
// No dependencies; every other file of the block imports it.
`default_nettype none

package wtm_pkg;

  localparam int NUM_VOICES  = 3;
  localparam int TABLE_SIZE  = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int TableHalf = TABLE_SIZE / 2;

  localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int PHASE_W = IDX_W + 8;
  localparam int STEP_W  = 12;
  localparam int VOL_W   = 8;
  localparam int FREQ_W  = 10;
  localparam int ENV_W   = 21;
  localparam int DECAY_W = 8;
  localparam int SUS_W   = 10;
  localparam int SMP_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = ENV_W + 1;
  localparam int MUL_B_W = SUS_W + 1;
  localparam int PROD_W  = 30;

  // Sum of terms, and the sum after the final shift left by five.
  localparam int ACC_W = 9 + $clog2(NUM_VOICES + 1);
  localparam int SUM_W = (ACC_W + 5 > 17) ? ACC_W + 5 : 17;

  localparam logic [15:0]      STEP_NUM  = 16'd47440;
  localparam logic [ENV_W-1:0] ENV_FULL  = ENV_W'(32'h100000);
  localparam logic [VOL_W-1:0] VOL_MUTE  = 8'd255;
  localparam logic [FREQ_W-1:0] FREQ_MIN = 10'd16;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 10'd960;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd3;

  typedef enum logic [1:0] {
    CMD_NOTE,
    CMD_SILENCE,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [VOICE_W-1:0] voice;
    logic [FREQ_W-1:0]  freq;
    logic [VOL_W-1:0]   vol;
  } cmd_t;

  typedef struct packed {
    logic               interp_enable;
    logic               env_enable;
    logic [DECAY_W-1:0] env_decay;
    logic [SUS_W-1:0]   env_sustain;
  } cfg_t;

  // Signed ramp: rising half up to 255, then a half rising up from minus.
  function automatic logic signed [8:0] ramp_entry(input logic [IDX_W-1:0] k);
    int ki;
    int val;
    logic signed [8:0] r;
    ki = int'(k);
    if (ki < TableHalf) begin
      val = (ki == TableHalf - 1) ? 255 : (ki * 256) / TableHalf;
    end else if (ki == TableHalf) begin
      val = 0;
    end else begin
      val = -(((TABLE_SIZE - ki) * 256) / TableHalf);
    end
    r = val[8:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/wtm_front.sv
// Front end of the wavetable tone mixer: takes input beats, classifies them
// into commands and holds them in a short queue for the back end. Uses wtm_pkg.
`default_nettype none

module wtm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [1:0]                voice_i,
  input  logic [wtm_pkg::FREQ_W-1:0] note_freq_i,
  input  logic [wtm_pkg::VOL_W-1:0]  note_volume_i,
  output logic                      q_valid_o,
  output wtm_pkg::cmd_t             q_cmd_o,
  input  logic                      q_pop_i
);
  import wtm_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  logic [3:0] voice_ext;
  logic       voice_ok, silent, accept, push, pop;
  cmd_t       cmd;

  assign voice_ext = {2'b00, voice_i};
  assign voice_ok  = (voice_ext < 4'(NUM_VOICES));
  assign silent    = (note_volume_i == VOL_MUTE) || (note_freq_i < FREQ_MIN) ||
                     (note_freq_i >= FREQ_MAX);

  always_comb begin
    cmd.voice = voice_ext[VOICE_W-1:0];
    cmd.freq  = note_freq_i;
    cmd.vol   = note_volume_i;
    if (mode_i) begin
      cmd.kind = CMD_TICK;
    end else if (silent) begin
      cmd.kind = CMD_SILENCE;
    end else begin
      cmd.kind = CMD_NOTE;
    end
  end

  assign in_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  // A note for a voice that does not exist is taken and dropped here.
  assign push       = accept && (mode_i || voice_ok);
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wtm_div.sv
// Restoring divider for the phase step: 47440 divided by the note frequency,
// one quotient bit per cycle. Uses wtm_pkg.
`default_nettype none

module wtm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wtm_pkg::FREQ_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [wtm_pkg::STEP_W-1:0] quot_o
);
  import wtm_pkg::*;

  logic              run_q, done_q;
  logic [3:0]        cnt_q;
  logic [FREQ_W-1:0] div_q, rem_q;
  logic [15:0]       quo_q;
  logic [FREQ_W:0]   rem_sh, rem_sub;
  logic              fits;

  assign rem_sh  = {rem_q, quo_q[15]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign fits    = (rem_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'd15) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= STEP_NUM;
    end else if (run_q) begin
      rem_q <= fits ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
      quo_q <= {quo_q[14:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[STEP_W-1:0];

endmodule

`default_nettype wire

>>> rtl/wtm_back.sv
// Back end of the wavetable tone mixer: voice state, the sequencer that runs
// note commands through the divider and sample commands through one shared
// multiplier, and the output register. Uses wtm_pkg and wtm_div.
`default_nettype none

module wtm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wtm_pkg::cfg_t             cfg_i,
  input  logic                      q_valid_i,
  input  wtm_pkg::cmd_t             q_cmd_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [wtm_pkg::SMP_W-1:0] sample_out_o
);
  import wtm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_V0   = 4'd2;
  localparam logic [3:0] S_V1   = 4'd3;
  localparam logic [3:0] S_V2   = 4'd4;
  localparam logic [3:0] S_V3   = 4'd5;
  localparam logic [3:0] S_V4   = 4'd6;
  localparam logic [3:0] S_V5   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic [PHASE_W:0] PhaseMod = (PHASE_W + 1)'(TABLE_SIZE * 256);
  localparam logic signed [SUM_W-1:0] SatMax = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SatMin = SUM_W'(-32768);

  logic [3:0] state_q, state_d;

  logic [PHASE_W-1:0] phase_q [NUM_VOICES];
  logic [STEP_W-1:0]  step_q  [NUM_VOICES];
  logic [VOL_W-1:0]   vol_q   [NUM_VOICES];
  logic [ENV_W-1:0]   env_q   [NUM_VOICES];

  logic [VOICE_W-1:0] v_q;
  logic [VOICE_W-1:0] nvoice_q;
  logic [VOL_W-1:0]   nvol_q;
  logic signed [8:0]  b_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic               out_valid_q;
  logic signed [SMP_W-1:0] sample_q;

  logic               pop, div_start, div_done;
  logic [STEP_W-1:0]  div_quot;
  logic               last_voice;

  logic [PHASE_W-1:0] phase;
  logic [VOL_W-1:0]   vol;
  logic [ENV_W-1:0]   env;
  logic [IDX_W-1:0]   idx, idx1;
  logic signed [8:0]  r0, r1;
  logic signed [9:0]  diff;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [9:0]  b_sum;
  logic [VOL_W-1:0]   scale;
  logic               env_above;
  logic [ENV_W-1:0]   env_next;
  logic [PHASE_W:0]   phase_sum;
  logic [PHASE_W-1:0] phase_next;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;

  logic signed [SUM_W-1:0] sum_sh;
  logic signed [SMP_W-1:0] sat;
  logic out_free;

  wtm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (q_cmd_i.freq),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign pop       = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o   = pop;
  assign div_start = pop && (q_cmd_i.kind == CMD_NOTE);
  assign last_voice = (v_q == VOICE_W'(NUM_VOICES - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  // Current voice fields.
  assign phase = phase_q[v_q];
  assign vol   = vol_q[v_q];
  assign env   = env_q[v_q];
  assign idx   = phase[PHASE_W-1:8];
  assign idx1  = (idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;
  assign r0    = ramp_entry(idx);
  assign r1    = ramp_entry(idx1);
  assign diff  = {r1[8], r1} - {r0[8], r0};

  // Floor shift of the registered product.
  assign prod_sh = prod_q >>> 8;
  assign b_sum   = {b_q[8], b_q} + prod_sh[9:0];
  assign scale   = cfg_i.env_enable ? prod_q[27:20] : vol;

  // Decay only while the level is above the sustain point; floor at zero.
  assign env_above = ({1'b0, env[ENV_W-1:4]} > prod_q[17:0]);
  assign env_next  = (env > ENV_W'(cfg_i.env_decay)) ? env - ENV_W'(cfg_i.env_decay) : '0;

  assign phase_sum  = {1'b0, phase} + (PHASE_W + 1)'(step_q[v_q]);
  assign phase_next = (phase_sum >= PhaseMod) ? PHASE_W'(phase_sum - PhaseMod)
                                              : phase_sum[PHASE_W-1:0];

  // The one multiplier, shared by the steps S_V0, S_V1, S_V3 and S_V4 of a voice.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_V0: begin
        mul_a = {{(MUL_A_W-10){diff[9]}}, diff};
        mul_b = {{(MUL_B_W-8){1'b0}}, idx == idx ? phase[7:0] : 8'd0};
      end
      S_V1: begin
        mul_a = {{(MUL_A_W-VOL_W){1'b0}}, vol};
        mul_b = {1'b0, cfg_i.env_sustain};
      end
      S_V3: begin
        mul_a = {1'b0, env};
        mul_b = {{(MUL_B_W-VOL_W){1'b0}}, vol};
      end
      S_V4: begin
        mul_a = {{(MUL_A_W-9){b_q[8]}}, b_q};
        mul_b = {{(MUL_B_W-VOL_W){1'b0}}, scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Final mix: shift left by five and saturate to 16 bits.
  assign sum_sh = {{(SUM_W-ACC_W){acc_q[ACC_W-1]}}, acc_q} <<< 5;
  always_comb begin
    priority if (sum_sh > SatMax) begin
      sat = SMP_W'(SatMax);
    end else if (sum_sh < SatMin) begin
      sat = SMP_W'(SatMin);
    end else begin
      sat = sum_sh[SMP_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          unique case (q_cmd_i.kind)
            CMD_NOTE: state_d = S_DIV;
            CMD_TICK: state_d = S_V0;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_DIV:   if (div_done) state_d = S_IDLE;
      S_V0: begin
        if (vol != '0) begin
          state_d = S_V1;
        end else if (last_voice) begin
          state_d = S_OUT;
        end
      end
      S_V1:    state_d = S_V2;
      S_V2:    state_d = S_V3;
      S_V3:    state_d = S_V4;
      S_V4:    state_d = S_V5;
      S_V5:    state_d = last_voice ? S_OUT : S_V0;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase_q[i] <= '0;
        step_q[i]  <= '0;
        vol_q[i]   <= '0;
        env_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop && q_cmd_i.kind == CMD_SILENCE) begin
        phase_q[q_cmd_i.voice] <= '0;
        step_q[q_cmd_i.voice]  <= '0;
        vol_q[q_cmd_i.voice]   <= '0;
        env_q[q_cmd_i.voice]   <= ENV_FULL;
      end
      if (state_q == S_DIV && div_done) begin
        phase_q[nvoice_q] <= '0;
        step_q[nvoice_q]  <= div_quot;
        vol_q[nvoice_q]   <= nvol_q;
        env_q[nvoice_q]   <= ENV_FULL;
      end
      if (pop && q_cmd_i.kind == CMD_TICK) begin
        v_q <= '0;
      end
      if (state_q == S_V2 && cfg_i.env_enable && env_above) begin
        env_q[v_q] <= env_next;
      end
      if (state_q == S_V5) begin
        phase_q[v_q] <= phase_next;
      end
      if ((state_q == S_V0 && vol == '0) || state_q == S_V5) begin
        if (!last_voice) begin
          v_q <= v_q + 1'b1;
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      nvoice_q <= q_cmd_i.voice;
      nvol_q   <= q_cmd_i.vol;
      acc_q    <= '0;
    end
    prod_q <= mul_p[PROD_W-1:0];
    if (state_q == S_V0) begin
      b_q <= r0;
    end
    if (state_q == S_V1 && cfg_i.interp_enable) begin
      b_q <= b_sum[8:0];
    end
    if (state_q == S_V5) begin
      acc_q <= acc_q + prod_sh[ACC_W-1:0];
    end
    if (state_q == S_OUT && out_free) begin
      sample_q <= sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;

endmodule

`default_nettype wire

>>> rtl/wavetable_tone_mixer.sv
// Top level of the wavetable tone mixer: configuration registers, front end
// and back end. Depends on wtm_pkg, wtm_front, wtm_back (and wtm_div below it).
//
// Usage. Input beats carry mode, voice, note_freq and note_volume. A beat with
// mode 0 is a note event for one voice and gives no output; a beat with mode 1
// is a sample tick and gives exactly one beat on the output channel
// (sample_out, signed 16 bits). Output beats come out in tick order.
// Configuration writes (index 0 interp_enable, 1 env_enable, 2 env_decay,
// 3 env_sustain) are registered at any time; cfg_ready is always high,
// but they are meant to be written while the block is idle.
// Timing. Beats go into a two-entry command queue, so input is taken while the
// back end works or while a finished sample waits on the output register.
// The back end runs one command at a time. A sample tick steps each sounding
// voice through states S_V0 to S_V5, visiting the shared multiplier four times,
// and passes a silent voice with S_V0 alone. A sounding note event waits on the
// bit-serial divider that forms its phase step; a note that silences its voice
// is applied as it is taken from the queue. Notes for a voice that does not
// exist are taken and dropped.
// Reset clears the queue, the output valid flag and all voices to silent, and
// loads the configuration defaults. When the receiver stalls, the sample holds
// on the output, the back end waits, and input stops once the queue is full.
`default_nettype none

module wavetable_tone_mixer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [1:0]                     voice_i,
  input  logic [wtm_pkg::FREQ_W-1:0]     note_freq_i,
  input  logic [wtm_pkg::VOL_W-1:0]      note_volume_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [wtm_pkg::SMP_W-1:0] sample_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wtm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wtm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wtm_pkg::*;

  // Configuration registers; the reset values are the defaults of the block.
  cfg_t cfg_q, cfg_d;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INTERP:  cfg_d.interp_enable = cfg_data_i[0];
        CFG_ENV_EN:  cfg_d.env_enable    = cfg_data_i[0];
        CFG_DECAY:   cfg_d.env_decay     = cfg_data_i[DECAY_W-1:0];
        CFG_SUSTAIN: cfg_d.env_sustain   = cfg_data_i[SUS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interp_enable <= 1'b1;
      cfg_q.env_enable    <= 1'b1;
      cfg_q.env_decay     <= 8'd32;
      cfg_q.env_sustain   <= 10'd160;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each beat into a note, a silencing note or a tick.
  wtm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .voice_i       (voice_i),
    .note_freq_i   (note_freq_i),
    .note_volume_i (note_volume_i),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd),
    .q_pop_i       (q_pop)
  );

  // The back end owns the voices, the divider, the multiplier and the output.
  wtm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire

>>> rtl/wtm_checker.sv
// Port-level checker for the wavetable tone mixer and the bind that attaches
// it to the top level. Uses wtm_pkg for widths.
`default_nettype none

module wtm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [wtm_pkg::SMP_W-1:0] sample_out_o
);
  import wtm_pkg::*;

  // A stalled output beat keeps its sample.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("output beat changed while stalled");

  // Nothing is offered on the output while reset is asserted.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // The queue only fills through an accepted input beat.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input ready dropped without an accepted beat");

  // The output register empties only when the receiver takes the beat.
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output beat vanished without being taken");

endmodule

bind wavetable_tone_mixer wtm_checker u_wtm_checker (.*);

`default_nettype wire
